/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/b64v_pkg.sv */
// ----------------------------------------------------------------------------
// b64v_pkg
// Types, constants and the digit-to-character map for the base64 variant
// encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64v_pkg;

   // Queue between front and back; depth must be a power of two.
   localparam int FifoDepth = 2;
   localparam int FifoPtrW  = $clog2(FifoDepth);

   typedef logic [7:0] char_type;
   typedef logic [5:0] digit_type;

   typedef enum logic [1:0] {
      CSR_DIGIT62 = 2'd0,
      CSR_DIGIT63 = 2'd1,
      CSR_PAD     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   localparam char_type Digit62Reset = 8'h2E;  // '.'
   localparam char_type Digit63Reset = 8'h5F;  // '_'
   localparam char_type PadReset     = 8'h2D;  // '-'

   localparam char_type CharUpperA = 8'h41;
   localparam char_type CharLowerA = 8'h61;
   localparam char_type CharZero   = 8'h30;

   // One queue entry: up to two digits, then pad characters up to count_m1.
   typedef struct packed {
      digit_type  d0;
      digit_type  d1;
      logic [1:0] count_m1;
      logic       last;
   } entry_type;

   function automatic char_type digit_to_char(digit_type d, char_type c62, char_type c63);
      char_type ch;
      if (d < 6'd26) begin
         ch = CharUpperA + 8'(d);
      end else if (d < 6'd52) begin
         ch = CharLowerA + 8'(d - 6'd26);
      end else if (d < 6'd62) begin
         ch = CharZero + 8'(d - 6'd52);
      end else if (d == 6'd62) begin
         ch = c62;
      end else begin
         ch = c63;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

/* hdl/b64v_channels.sv */
// ----------------------------------------------------------------------------
// b64v channels
// Valid/ready channel interfaces for input bytes, output characters and
// register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface b64v_req_if;
   import b64v_pkg::*;
   logic     valid;
   logic     ready;
   char_type in_byte;
   logic     in_last;
   modport source (output valid, in_byte, in_last, input ready);
   modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface b64v_rsp_if;
   import b64v_pkg::*;
   logic     valid;
   logic     ready;
   char_type out_char;
   logic     out_last;
   modport source (output valid, out_char, out_last, input ready);
   modport sink   (input valid, out_char, out_last, output ready);
endinterface

interface b64v_csr_if;
   import b64v_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   char_type   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/b64v_front.sv */
// ----------------------------------------------------------------------------
// b64v_front
// Accepts input bytes, tracks the group phase and leftover bits, and turns
// each byte into a queue entry of digits and pad count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64v_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   b64v_req_if.sink                  req_ch,
   output b64v_pkg::entry_type       push_data,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output b64v_pkg::phase_type       phase
);
   import b64v_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic       accept;
   char_type   b;
   logic       lst;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign accept       = req_ch.valid && push_ready;
   assign phase        = phase_ff;
   assign b            = req_ch.in_byte;
   assign lst          = req_ch.in_last;

   always_comb begin
      push_data.last = lst;
      unique case (phase_ff)
         PH_SECOND: begin
            push_data.d0       = {carry_ff[1:0], b[7:4]};
            push_data.d1       = {b[3:0], 2'b00};
            push_data.count_m1 = lst ? 2'd2 : 2'd0;
            phase_in           = lst ? PH_FIRST : PH_THIRD;
            carry_in           = lst ? 4'd0 : b[3:0];
         end
         PH_THIRD: begin
            push_data.d0       = {carry_ff, b[7:6]};
            push_data.d1       = b[5:0];
            push_data.count_m1 = 2'd1;
            phase_in           = PH_FIRST;
            carry_in           = 4'd0;
         end
         default: begin
            // first byte of a group; the unused phase code behaves the same
            push_data.d0       = b[7:2];
            push_data.d1       = {b[1:0], 4'b0000};
            push_data.count_m1 = lst ? 2'd3 : 2'd0;
            phase_in           = lst ? PH_FIRST : PH_SECOND;
            carry_in           = lst ? 4'd0 : {2'b00, b[1:0]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/b64v_fifo.sv */
// ----------------------------------------------------------------------------
// b64v_fifo
// Short entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64v_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire b64v_pkg::entry_type  push_data,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   output b64v_pkg::entry_type       pop_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready
);
   import b64v_pkg::*;

   entry_type           mem_ff [FifoDepth];
   logic [FifoPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FifoPtrW:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = count_ff != (FifoPtrW + 1)'(FifoDepth);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/b64v_back.sv */
// ----------------------------------------------------------------------------
// b64v_back
// Walks the head queue entry one character a cycle into the output register while rsp_ch does not stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64v_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire b64v_pkg::entry_type  head,
   input  wire logic                 head_valid,
   output logic                      pop,
   input  wire b64v_pkg::char_type   digit62,
   input  wire b64v_pkg::char_type   digit63,
   input  wire b64v_pkg::char_type   pad,
   b64v_rsp_if.source                rsp_ch,
   output logic [1:0]                idx
);
   import b64v_pkg::*;

   logic       valid_ff;
   char_type   char_ff, char_in;
   logic       last_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load, emit, is_end;

   assign load   = !valid_ff || rsp_ch.ready;
   assign emit   = load && head_valid;
   assign is_end = idx_ff == head.count_m1;
   assign pop    = emit && is_end;
   assign idx    = idx_ff;

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_char = char_ff;
   assign rsp_ch.out_last = last_ff;

   always_comb begin
      unique case (idx_ff)
         2'd0:    char_in = digit_to_char(head.d0, digit62, digit63);
         2'd1:    char_in = digit_to_char(head.d1, digit62, digit63);
         default: char_in = pad;
      endcase
      if (pop) begin
         idx_in = 2'd0;
      end else if (emit) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= head_valid;
         end
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff <= char_in;
         last_ff <= head.last && is_end;
      end
   end

endmodule

`default_nettype wire

/* hdl/base64_variant_encoder.sv */
// ----------------------------------------------------------------------------
// base64_variant_encoder
// Byte-in, character-out base64 variant encoder with programmable characters
// for digits 62 and 63 and for the pad.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req_ch   in   valid / ready      in_byte[7:0], in_last
//  rsp_ch   out  valid / ready      out_char[7:0], out_last
//  csr_ch   in   valid / ready (1)  index[1:0], data[7:0]
//
//  One character leaves per cycle from the output register while rsp_ch takes it;
//  the back part's single character path sets the rate: one character per byte
//  for the first two bytes of a group, two for the third, up to four for a last byte.
//  A byte is taken every cycle while the two-entry queue has room, also while
//  a character waits on rsp_ch. Synchronous reset restores the default
//  characters and the start of a group; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module base64_variant_encoder (
   input wire logic   clock,
   input wire logic   reset,
   b64v_req_if.sink   req_ch,
   b64v_rsp_if.source rsp_ch,
   b64v_csr_if.sink   csr_ch
);
   import b64v_pkg::*;

   char_type   digit62_ff, digit63_ff, pad_ff;
   entry_type  push_data, head;
   logic       push_valid, push_ready;
   logic       head_valid, pop;
   phase_type  front_phase;
   logic [1:0] back_idx;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit62_ff <= Digit62Reset;
         digit63_ff <= Digit63Reset;
         pad_ff     <= PadReset;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DIGIT62: digit62_ff <= csr_ch.data;
            CSR_DIGIT63: digit63_ff <= csr_ch.data;
            CSR_PAD:     pad_ff     <= csr_ch.data;
            default: ;
         endcase
      end
   end

   b64v_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .phase      (front_phase)
   );

   b64v_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (head),
      .pop_valid  (head_valid),
      .pop_ready  (pop)
   );

   b64v_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .digit62    (digit62_ff),
      .digit63    (digit63_ff),
      .pad        (pad_ff),
      .rsp_ch     (rsp_ch),
      .idx        (back_idx)
   );

   `ASSERT_NEXT(a_push_lands, clock, reset, req_ch.valid && req_ch.ready, head_valid, "accepted item missing from queue")
   `ASSERT_NEXT(a_last_rephase, clock, reset, req_ch.valid && req_ch.ready && req_ch.in_last, front_phase == PH_FIRST, "group phase not restarted after last byte")
   `ASSERT_NOW(a_idle_idx, clock, reset, !head_valid, back_idx == 2'd0, "character index left over with empty queue")

endmodule

`default_nettype wire
